// ===== src/fha_pkg.sv =====
package fha_pkg;

   // fixed port widths
   localparam int SIZE_W     = 16;
   localparam int ADDR_OUT_W = 12;
   localparam int USED_W     = 13;

   // internal arithmetic width, holds any offset or rounded size
   localparam int DATA_W = 18;

   localparam int MIN_BLOCK = 12;
   localparam int USED_MAX  = 8191;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_SPLIT,
      ST_C_RD,
      ST_C_CHK,
      ST_F_RD,
      ST_F_CHK,
      ST_F_NX,
      ST_F_PRD,
      ST_F_PV,
      ST_F_WB,
      ST_RESP
   } state_type;

endpackage

// ===== src/fha_store.sv =====
module fha_store #(
   parameter int DEPTH = 1024,
   parameter int IW    = 10
) (
   input  logic          clock,
   input  logic          meta_we,
   input  logic [IW-1:0] meta_waddr,
   input  logic [IW+1:0] meta_wdata,
   input  logic [IW-1:0] meta_raddr,
   output logic [IW+1:0] meta_rdata,
   input  logic          prev_we,
   input  logic [IW-1:0] prev_waddr,
   input  logic [IW-1:0] prev_wdata,
   input  logic [IW-1:0] prev_raddr,
   output logic [IW-1:0] prev_rdata
);

   // meta word: valid, used, next header index
   logic [IW+1:0] meta_mem [DEPTH];
   logic [IW-1:0] prev_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rdata <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rdata <= prev_mem[prev_raddr];
   end

endmodule

// ===== src/fha_ctrl.sv =====
module fha_ctrl #(
   parameter int HEAP_BYTES   = 4096,
   parameter int ALIGN_BYTES  = 4,
   parameter int HEADER_BYTES = 12,
   parameter int GRAN         = 4,
   parameter int DEPTH        = 1024,
   parameter int IW           = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [fha_pkg::SIZE_W-1:0]       req_size,
   input  logic [fha_pkg::SIZE_W-1:0]       req_free_addr,
   output logic                             rsp_valid,
   output logic                             rsp_granted,
   output logic [fha_pkg::ADDR_OUT_W-1:0]   rsp_block_addr,
   output logic [fha_pkg::USED_W-1:0]       rsp_used_bytes,
   output logic                             meta_we,
   output logic [IW-1:0]                    meta_waddr,
   output logic [IW+1:0]                    meta_wdata,
   output logic [IW-1:0]                    meta_raddr,
   input  logic [IW+1:0]                    meta_rdata,
   output logic                             prev_we,
   output logic [IW-1:0]                    prev_waddr,
   output logic [IW-1:0]                    prev_wdata,
   output logic [IW-1:0]                    prev_raddr,
   input  logic [IW-1:0]                    prev_rdata
);

   localparam int DW       = fha_pkg::DATA_W;
   localparam int END_OFF  = HEAP_BYTES - HEADER_BYTES;
   localparam int TOTAL    = HEAP_BYTES - 2 * HEADER_BYTES;
   localparam int HDR_IDX  = HEADER_BYTES / GRAN;
   localparam logic [IW-1:0] END_IDX = IW'(END_OFF / GRAN);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [DW-1:0] HDR_D   = DW'(HEADER_BYTES);
   localparam logic [DW-1:0] GRAN_D  = DW'(GRAN);
   localparam logic [DW-1:0] MIN_D   = DW'(fha_pkg::MIN_BLOCK);
   localparam logic [DW-1:0] ALIGN_D = DW'(ALIGN_BYTES);
   localparam logic [DW-1:0] TOTAL_D = DW'(TOTAL);
   localparam logic [DW-1:0] ENDO_D  = DW'(END_OFF);
   localparam logic [DW-1:0] UMAX_D  = DW'(fha_pkg::USED_MAX);
   localparam logic [DW-1:0] SPLIT_D = DW'(HEADER_BYTES + fha_pkg::MIN_BLOCK);
   // reciprocal of the alignment, exact for any size below 2^17
   localparam int RCP_SH = 22;
   localparam int RCP_W  = 23;
   localparam logic [RCP_W-1:0] RCP = RCP_W'((2 ** RCP_SH + ALIGN_BYTES - 1) / ALIGN_BYTES);

   fha_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                  clr_ff, clr_in;
   logic [IW-1:0]                  cur_ff, cur_in;
   logic [IW-1:0]                  nxt_ff, nxt_in;
   logic [IW-1:0]                  hn_ff, hn_in;
   logic [IW-1:0]                  prv_ff, prv_in;
   logic [IW-1:0]                  cw_ff, cw_in;
   logic [fha_pkg::USED_W-1:0]     used_ff, used_in;
   logic [DW-1:0]                  size_ff, size_in;
   logic [DW-1:0]                  fsize_ff, fsize_in;
   logic                           grant_ff, grant_in;
   logic [fha_pkg::ADDR_OUT_W-1:0] baddr_ff, baddr_in;
   logic                           merged_ff, merged_in;

   // read data fields
   logic          m_v, m_u;
   logic [IW-1:0] m_n;
   assign m_v = meta_rdata[IW+1];
   assign m_u = meta_rdata[IW];
   assign m_n = meta_rdata[IW-1:0];

   // request checks
   logic [DW-1:0] a_size, r_size, remain, u_d;
   logic [DW-1:0] a_up, a_q;
   logic [DW+RCP_W-1:0] a_prod;
   logic          a_ok;
   logic [DW-1:0] fa, fh;
   logic          f_ok;
   assign u_d    = DW'(used_ff);
   assign a_size = (DW'(req_size) < MIN_D) ? MIN_D : DW'(req_size);
   // round up to the alignment by reciprocal multiply
   assign a_up   = a_size + ALIGN_D - 1'b1;
   assign a_prod = (DW+RCP_W)'(a_up) * (DW+RCP_W)'(RCP);
   assign a_q    = a_prod[RCP_SH +: DW];
   assign r_size = a_q * ALIGN_D;
   assign remain = (u_d >= TOTAL_D) ? '0 : TOTAL_D - u_d;
   assign a_ok   = (req_size != '0) && (r_size <= remain);
   assign fa     = DW'(req_free_addr);
   assign fh     = fa - HDR_D;
   assign f_ok   = (fa != '0) && (fa < ENDO_D) && (fa >= HDR_D) && ((fh % GRAN_D) == '0);

   // block fit for the header under the walk
   logic [DW-1:0] c_off, n_off, blen, s_d, add_d;
   logic          fit, split;
   assign c_off = DW'(cur_ff) * GRAN_D;
   assign n_off = DW'(m_n) * GRAN_D;
   assign blen  = (n_off > c_off + HDR_D) ? n_off - c_off - HDR_D : '0;
   assign fit   = !m_u && (blen > size_ff);
   assign split = (blen - size_ff) > SPLIT_D;
   assign s_d   = DW'(cur_ff) + DW'(HDR_IDX) + size_ff / GRAN_D;
   assign add_d = u_d + size_ff + HDR_D;

   logic [IW-1:0] keep;
   assign keep = merged_ff ? prv_ff : cur_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fha_pkg::ST_CLEAR:   if (clr_ff == LAST_IDX) state_in = fha_pkg::ST_IDLE;
         fha_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == fha_pkg::REQ_ALLOC) begin
                  state_in = a_ok ? fha_pkg::ST_A_RD : fha_pkg::ST_RESP;
               end else begin
                  state_in = f_ok ? fha_pkg::ST_F_RD : fha_pkg::ST_RESP;
               end
            end
         end
         fha_pkg::ST_A_RD: begin
            state_in = (cur_ff >= END_IDX) ? fha_pkg::ST_RESP : fha_pkg::ST_A_CHK;
         end
         fha_pkg::ST_A_CHK: begin
            if (!m_v) begin
               state_in = fha_pkg::ST_RESP;
            end else if (fit) begin
               if (split) state_in = fha_pkg::ST_A_SPLIT;
               else state_in = (cw_ff == cur_ff) ? fha_pkg::ST_C_RD : fha_pkg::ST_RESP;
            end else begin
               state_in = fha_pkg::ST_A_RD;
            end
         end
         fha_pkg::ST_A_SPLIT: begin
            state_in = (cw_ff == cur_ff) ? fha_pkg::ST_C_RD : fha_pkg::ST_RESP;
         end
         fha_pkg::ST_C_RD: begin
            state_in = (cw_ff >= END_IDX) ? fha_pkg::ST_RESP : fha_pkg::ST_C_CHK;
         end
         fha_pkg::ST_C_CHK:   state_in = m_u ? fha_pkg::ST_C_RD : fha_pkg::ST_RESP;
         fha_pkg::ST_F_RD:    state_in = fha_pkg::ST_F_CHK;
         fha_pkg::ST_F_CHK: begin
            if (!(m_v && m_u)) state_in = fha_pkg::ST_RESP;
            else state_in = (m_n < END_IDX) ? fha_pkg::ST_F_NX : fha_pkg::ST_F_PRD;
         end
         fha_pkg::ST_F_NX:    state_in = fha_pkg::ST_F_PRD;
         fha_pkg::ST_F_PRD: begin
            state_in = (cur_ff == '0) ? fha_pkg::ST_F_WB : fha_pkg::ST_F_PV;
         end
         fha_pkg::ST_F_PV:    state_in = fha_pkg::ST_F_WB;
         fha_pkg::ST_F_WB:    state_in = fha_pkg::ST_RESP;
         fha_pkg::ST_RESP:    state_in = fha_pkg::ST_IDLE;
         default:             state_in = fha_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      clr_in     = clr_ff;
      cur_in     = cur_ff;
      nxt_in     = nxt_ff;
      hn_in      = hn_ff;
      prv_in     = prv_ff;
      cw_in      = cw_ff;
      used_in    = used_ff;
      size_in    = size_ff;
      fsize_in   = fsize_ff;
      grant_in   = grant_ff;
      baddr_in   = baddr_ff;
      merged_in  = merged_ff;
      meta_we    = 1'b0;
      meta_waddr = cur_ff;
      meta_wdata = '0;
      meta_raddr = cur_ff;
      prev_we    = 1'b0;
      prev_waddr = cur_ff;
      prev_wdata = '0;
      prev_raddr = cur_ff;
      unique case (state_ff)
         fha_pkg::ST_CLEAR: begin
            // begin guard free up to end guard, end guard used
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            prev_we    = 1'b1;
            prev_waddr = clr_ff;
            if (clr_ff == '0) begin
               meta_wdata = {1'b1, 1'b0, END_IDX};
               prev_wdata = END_IDX;
            end else if (clr_ff == END_IDX) begin
               meta_wdata = {1'b1, 1'b1, {IW{1'b0}}};
            end
            clr_in = clr_ff + 1'b1;
         end
         fha_pkg::ST_IDLE: begin
            if (start) begin
               grant_in  = 1'b0;
               baddr_in  = '0;
               merged_in = 1'b0;
               size_in   = r_size;
               cur_in    = (req_type == fha_pkg::REQ_ALLOC) ? cw_ff : IW'(fh / GRAN_D);
            end
         end
         fha_pkg::ST_A_RD: meta_raddr = cur_ff;
         fha_pkg::ST_A_CHK: begin
            if (m_v && fit) begin
               grant_in = 1'b1;
               baddr_in = fha_pkg::ADDR_OUT_W'(c_off + HDR_D);
               used_in  = (add_d > UMAX_D) ? fha_pkg::USED_W'(UMAX_D)
                                           : fha_pkg::USED_W'(add_d);
               nxt_in   = m_n;
               hn_in    = IW'(s_d);
               meta_we  = 1'b1;
               if (split) begin
                  meta_waddr = IW'(s_d);
                  meta_wdata = {1'b1, 1'b0, m_n};
                  prev_we    = 1'b1;
                  prev_waddr = IW'(s_d);
                  prev_wdata = cur_ff;
               end else begin
                  meta_waddr = cur_ff;
                  meta_wdata = {1'b1, 1'b1, m_n};
               end
            end else if (m_v) begin
               cur_in = m_n;
            end
         end
         fha_pkg::ST_A_SPLIT: begin
            meta_we    = 1'b1;
            meta_waddr = cur_ff;
            meta_wdata = {1'b1, 1'b1, hn_ff};
            prev_we    = 1'b1;
            prev_waddr = nxt_ff;
            prev_wdata = hn_ff;
         end
         fha_pkg::ST_C_RD:  meta_raddr = cw_ff;
         fha_pkg::ST_C_CHK: if (m_u) cw_in = m_n;
         fha_pkg::ST_F_RD: begin
            meta_raddr = cur_ff;
            prev_raddr = cur_ff;
         end
         fha_pkg::ST_F_CHK: begin
            if (m_v && m_u) begin
               grant_in   = 1'b1;
               nxt_in     = m_n;
               hn_in      = m_n;
               prv_in     = prev_rdata;
               fsize_in   = (n_off > c_off) ? n_off - c_off : '0;
               meta_raddr = m_n;
            end
         end
         fha_pkg::ST_F_NX: begin
            if (m_v && !m_u) begin
               meta_we    = 1'b1;
               meta_waddr = nxt_ff;
               meta_wdata = '0;
               hn_in      = m_n;
               prev_we    = 1'b1;
               prev_waddr = m_n;
               prev_wdata = cur_ff;
            end
         end
         fha_pkg::ST_F_PRD: meta_raddr = prv_ff;
         fha_pkg::ST_F_PV: begin
            if (m_v && !m_u) begin
               merged_in  = 1'b1;
               meta_we    = 1'b1;
               meta_waddr = prv_ff;
               meta_wdata = {1'b1, 1'b0, hn_ff};
               prev_we    = 1'b1;
               prev_waddr = hn_ff;
               prev_wdata = prv_ff;
            end
         end
         fha_pkg::ST_F_WB: begin
            meta_we    = 1'b1;
            meta_waddr = cur_ff;
            meta_wdata = {!merged_ff, 1'b0, hn_ff};
            if (keep < cw_ff) cw_in = keep;
            used_in = (u_d > fsize_ff) ? fha_pkg::USED_W'(u_d - fsize_ff) : '0;
         end
         fha_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fha_pkg::ST_CLEAR;
         clr_ff   <= '0;
         cw_ff    <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cw_ff    <= cw_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      nxt_ff    <= nxt_in;
      hn_ff     <= hn_in;
      prv_ff    <= prv_in;
      size_ff   <= size_in;
      fsize_ff  <= fsize_in;
      grant_ff  <= grant_in;
      baddr_ff  <= baddr_in;
      merged_ff <= merged_in;
   end

   assign busy           = (state_ff != fha_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == fha_pkg::ST_RESP);
   assign rsp_granted    = grant_ff;
   assign rsp_block_addr = baddr_ff;
   assign rsp_used_bytes = used_ff;

`ifndef SYNTHESIS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fha_pkg::ST_CLEAR) |-> (cw_ff <= END_IDX))
      else $error("free cursor beyond end guard");
   a_refused_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_block_addr == '0))
      else $error("refused beat carries an address");
   a_free_no_growth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fha_pkg::ST_F_WB) |=> (used_ff <= $past(used_ff)))
      else $error("used count grew on free");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");
`endif

endmodule

// ===== src/first_fit_heap_allocator.sv =====
// channel  | ports                                              | handshake
// request  | req_type, req_size, req_free_addr                  | start && !busy
// response | rsp_granted, rsp_block_addr, rsp_used_bytes       | rsp_valid, one cycle
//
// an allocate walks the block list from the free cursor, one header per meta
// memory read, then may walk the cursor past used blocks the same way; a free
// reads its header, then the next and previous headers for the neighbor merges
// after reset a clearing pass writes every header entry, one slot per cycle,
// with busy high
// the response strobe lasts one cycle and cannot be held off
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = 4096,
   parameter int ALIGN_BYTES  = 4,
   parameter int HEADER_BYTES = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [fha_pkg::SIZE_W-1:0]       req_size,
   input  logic [fha_pkg::SIZE_W-1:0]       req_free_addr,
   output logic                             rsp_valid,
   output logic                             rsp_granted,
   output logic [fha_pkg::ADDR_OUT_W-1:0]   rsp_block_addr,
   output logic [fha_pkg::USED_W-1:0]       rsp_used_bytes
);

   // headers sit on a grid of the alignment when it is a power of two and the header
   // and heap sizes keep it, otherwise on every byte
   localparam int GRAN = (((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0)
                          && ((HEADER_BYTES % ALIGN_BYTES) == 0)
                          && ((HEAP_BYTES % ALIGN_BYTES) == 0)) ? ALIGN_BYTES : 1;
   localparam int DEPTH = HEAP_BYTES / GRAN;
   localparam int IW    = $clog2(DEPTH);

   logic          meta_we;
   logic [IW-1:0] meta_waddr;
   logic [IW+1:0] meta_wdata;
   logic [IW-1:0] meta_raddr;
   logic [IW+1:0] meta_rdata;
   logic          prev_we;
   logic [IW-1:0] prev_waddr;
   logic [IW-1:0] prev_wdata;
   logic [IW-1:0] prev_raddr;
   logic [IW-1:0] prev_rdata;

   // header list: valid, used and next link in one memory, back link in another
   fha_store #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_store (
      .clock      (clock),
      .meta_we    (meta_we),
      .meta_waddr (meta_waddr),
      .meta_wdata (meta_wdata),
      .meta_raddr (meta_raddr),
      .meta_rdata (meta_rdata),
      .prev_we    (prev_we),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata),
      .prev_raddr (prev_raddr),
      .prev_rdata (prev_rdata)
   );

   // sequencer: list walk, split, merge, cursor and used count
   fha_ctrl #(
      .HEAP_BYTES   (HEAP_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .GRAN         (GRAN),
      .DEPTH        (DEPTH),
      .IW           (IW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_size       (req_size),
      .req_free_addr  (req_free_addr),
      .rsp_valid      (rsp_valid),
      .rsp_granted    (rsp_granted),
      .rsp_block_addr (rsp_block_addr),
      .rsp_used_bytes (rsp_used_bytes),
      .meta_we        (meta_we),
      .meta_waddr     (meta_waddr),
      .meta_wdata     (meta_wdata),
      .meta_raddr     (meta_raddr),
      .meta_rdata     (meta_rdata),
      .prev_we        (prev_we),
      .prev_waddr     (prev_waddr),
      .prev_wdata     (prev_wdata),
      .prev_raddr     (prev_raddr),
      .prev_rdata     (prev_rdata)
   );

endmodule

// ===== test/testbench.sv =====
module testbench;

   localparam int HEAP      = 4096;
   localparam int HDR       = 12;
   localparam int ALIGN     = 4;
   localparam int END_HDR   = HEAP - HDR;
   localparam int TOTAL     = HEAP - 2 * HDR;
   localparam int N_RANDOM  = 1730;

   // one response beat
   typedef struct {
      bit          granted;
      bit [11:0]   blk;
      bit [12:0]   used;
   } heap_resp_type;

   // one row of the directed table, typed means the expected beat is written out
   typedef struct {
      logic          kind;
      int            size;
      int            addr;
      bit            typed;
      heap_resp_type want;
   } heap_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = fha_pkg::REQ_ALLOC;
   logic [15:0] req_size = '0;
   logic [15:0] req_free_addr = '0;
   logic        rsp_valid;
   logic        rsp_granted;
   logic [11:0] rsp_block_addr;
   logic [12:0] rsp_used_bytes;

   first_fit_heap_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_size(req_size), .req_free_addr(req_free_addr),
      .rsp_valid(rsp_valid), .rsp_granted(rsp_granted),
      .rsp_block_addr(rsp_block_addr), .rsp_used_bytes(rsp_used_bytes)
   );

   always #1 clock = ~clock;

   // shadow copy of the block list, indexed by header byte offset
   bit          blk_valid [HEAP];
   bit          blk_used  [HEAP];
   int unsigned blk_next  [HEAP];
   int unsigned blk_prev  [HEAP];
   int unsigned cursor;
   int unsigned used_total;

   heap_resp_type pending_resp[$];
   int          live_addrs[$];     // payload offsets currently handed out
   int          mismatches = 0;
   int          n_alloc_ok = 0, n_free_ok = 0, n_refused = 0, n_beats = 0;

   task automatic heap_clear();
      for (int i = 0; i < HEAP; i++) begin
         blk_valid[i] = 0; blk_used[i] = 0; blk_next[i] = 0; blk_prev[i] = 0;
      end
      blk_valid[0] = 1; blk_next[0] = END_HDR; blk_prev[0] = END_HDR;
      blk_valid[END_HDR] = 1; blk_used[END_HDR] = 1;
      cursor = 0;
      used_total = 0;
   endtask

   function automatic heap_resp_type pack_resp(bit ok, int unsigned blk);
      heap_resp_type r;
      r.granted = ok;
      r.blk = blk[11:0];
      r.used = used_total[12:0];
      return r;
   endfunction

   // first-fit allocate: size floor, align, budget check, walk from the cursor
   function automatic heap_resp_type heap_alloc(int unsigned size);
      int unsigned cur, nxt, len, remain, s;
      if (size == 0) return pack_resp(0, 0);
      if (size < fha_pkg::MIN_BLOCK) size = fha_pkg::MIN_BLOCK;
      size = (size + ALIGN - 1) / ALIGN * ALIGN;
      remain = (used_total >= TOTAL) ? 0 : TOTAL - used_total;
      if (size > remain) return pack_resp(0, 0);
      cur = cursor;
      for (int step = 0; step < HEAP; step++) begin
         if (cur >= END_HDR || !blk_valid[cur]) break;
         nxt = blk_next[cur];
         len = (nxt > cur + HDR) ? nxt - cur - HDR : 0;
         if (!blk_used[cur] && len > size) begin
            // split only when the leftover is larger than a header plus a minimum block
            if (len - size > HDR + fha_pkg::MIN_BLOCK) begin
               s = cur + HDR + size;
               if (s < HEAP) begin
                  blk_valid[s] = 1; blk_used[s] = 0;
                  blk_next[s] = nxt; blk_prev[s] = cur;
                  if (nxt < HEAP) blk_prev[nxt] = s;
                  blk_next[cur] = s;
               end
            end
            blk_used[cur] = 1;
            used_total += size + HDR;
            if (used_total > fha_pkg::USED_MAX) used_total = fha_pkg::USED_MAX;
            // cursor skips forward over used blocks, may land on the end guard
            if (cursor == cur) begin
               for (int k = 0; k < HEAP; k++) begin
                  if (cursor >= END_HDR || !blk_used[cursor]) break;
                  cursor = blk_next[cursor];
                  if (cursor >= HEAP) begin
                     cursor = END_HDR;
                     break;
                  end
               end
            end
            return pack_resp(1, cur + HDR);
         end
         cur = nxt;
      end
      return pack_resp(0, 0);
   endfunction

   // release with merge into free neighbors on both sides
   function automatic heap_resp_type heap_release(int unsigned addr);
      int unsigned h, nxt, prv, size, keep, n2, n;
      if (addr == 0 || addr >= END_HDR || addr < HDR) return pack_resp(0, 0);
      h = addr - HDR;
      if (!blk_valid[h] || !blk_used[h]) return pack_resp(0, 0);
      blk_used[h] = 0;
      nxt = blk_next[h];
      size = (nxt > h) ? nxt - h : 0;
      if (nxt < END_HDR && blk_valid[nxt] && !blk_used[nxt]) begin
         n2 = blk_next[nxt];
         blk_valid[nxt] = 0;
         blk_next[h] = n2;
         if (n2 < HEAP) blk_prev[n2] = h;
      end
      keep = h;
      if (h != 0) begin
         prv = blk_prev[h];
         if (prv < HEAP && blk_valid[prv] && !blk_used[prv]) begin
            n = blk_next[h];
            blk_next[prv] = n;
            if (n < HEAP) blk_prev[n] = prv;
            blk_valid[h] = 0;
            keep = prv;
         end
      end
      if (keep < cursor) cursor = keep;
      used_total = (used_total > size) ? used_total - size : 0;
      return pack_resp(1, 0);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // drive one beat at the falling edge, hold until accepted, then predict
   task automatic send_beat(logic kind, int size, int addr, bit typed, heap_resp_type want,
                            bit may_idle);
      heap_resp_type r;
      int idx;
      if (may_idle && $urandom_range(99) < 8) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start = 1'b1;
      req_type = kind;
      req_size = size[15:0];
      req_free_addr = addr[15:0];
      do @(posedge clock); while (busy);
      // accepted at this edge
      if (kind == fha_pkg::REQ_FREE) r = heap_release(addr[15:0]);
      else r = heap_alloc(size[15:0]);
      if (r.granted && kind == fha_pkg::REQ_ALLOC) begin
         live_addrs.push_back(r.blk);
         n_alloc_ok++;
      end else if (r.granted) begin
         foreach (live_addrs[i]) if (live_addrs[i] == addr[15:0]) idx = i;
         live_addrs.delete(idx);
         n_free_ok++;
      end else n_refused++;
      pending_resp.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   // response checker, compares each strobe with the oldest expected beat
   always @(posedge clock) begin
      heap_resp_type w;
      if (!reset && rsp_valid) begin
         n_beats++;
         if (pending_resp.size() == 0) begin
            report_mismatch("unexpected beat count", 1, 0);
         end else begin
            w = pending_resp.pop_front();
            if (rsp_granted !== w.granted) report_mismatch("granted", rsp_granted, w.granted);
            if (rsp_block_addr !== w.blk) report_mismatch("block_addr", rsp_block_addr, w.blk);
            if (rsp_used_bytes !== w.used) report_mismatch("used_bytes", rsp_used_bytes, w.used);
         end
      end
   end

   // directed rows; expected values typed in only for the obvious ones
   function automatic heap_row_type row(logic k, int s, int a, bit t = 0, bit g = 0,
                                        int b = 0, int u = 0);
      heap_row_type x;
      x.kind = k; x.size = s; x.addr = a; x.typed = t;
      x.want.granted = g; x.want.blk = b; x.want.used = u;
      return x;
   endfunction

   initial begin
      heap_row_type table_rows[$];
      heap_resp_type none;
      logic kind;
      int size, addr, pick;

      heap_clear();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fresh heap: min-size alloc splits the whole free area
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 1,     0,     1, 1, 12, 24));
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 0,     0,     1, 0, 0,  24));  // zero size
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 65535, 0,     1, 0, 0,  24));  // over budget
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     0,     1, 0, 0,  24));  // offset zero
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     END_HDR, 1, 0, 0, 24)); // end guard
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     65535, 1, 0, 0,  24));
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     12,    1, 1, 0,  0));   // merges fwd
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, TOTAL, 0,     1, 0, 0,  0));   // strict >
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, TOTAL - 4, 0, 1, 1, 12,
                               TOTAL - 4 + HDR));                                 // no split
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 1,     0,     1, 0, 0,  TOTAL + 8));
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     12,    1, 1, 0,  0));
      // mixed sequence checked by the predictor
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 13,    0));
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 12,    0));
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 100,   0));
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 3,     0));
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     40));   // middle block
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     40));   // double free
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     13));   // not on a header
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     11));   // below the first header
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 8,     0));
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     12));
      table_rows.push_back(row(fha_pkg::REQ_FREE,  0,     24));
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 4000,  0));
      table_rows.push_back(row(fha_pkg::REQ_ALLOC, 65534, 0));

      foreach (table_rows[i])
         send_beat(table_rows[i].kind, table_rows[i].size, table_rows[i].addr,
                   table_rows[i].typed, table_rows[i].want, 1);

      // random part: mostly real allocs and frees of live blocks, some noise
      for (int n = 0; n < N_RANDOM; n++) begin
         pick = $urandom_range(99);
         addr = 0; size = 0;
         if (pick < 50 + (live_addrs.size() < 4 ? 20 : 0)) begin
            kind = fha_pkg::REQ_ALLOC;
            case ($urandom_range(9))
               0:       size = $urandom_range(65535);
               1:       size = $urandom_range(2047);
               2:       size = 0;
               default: size = $urandom_range(1, 160);
            endcase
         end else begin
            kind = fha_pkg::REQ_FREE;
            if (live_addrs.size() > 0 && $urandom_range(9) < 8)
               addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
            else if ($urandom_range(1))
               addr = $urandom_range(65535);
            else
               addr = $urandom_range(HEAP - 1);
         end
         // a long stretch in the middle runs back to back
         send_beat(kind, size, addr, 0, none, !(n >= 600 && n < 900));
      end
      start = 1'b0;

      while (pending_resp.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("%0d beats checked: %0d allocs granted, %0d frees applied, %0d refused",
               n_beats, n_alloc_ok, n_free_ok, n_refused);
      if (mismatches == 0 && pending_resp.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
